@@ rtl/d2q9_pkg.sv @@
package d2q9_pkg;

  localparam int unsigned DataWidth   = 24;
  localparam int unsigned FracBits    = 20;
  localparam int unsigned RateWidth   = 21;
  localparam int unsigned RateFrac    = 20;
  localparam int unsigned SpeedWidth  = 24;
  localparam int unsigned CfgWidth    = 24;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned NumDir      = 9;

  // nine-term density sum and six-term momentum sums
  localparam int unsigned SumWidth  = DataWidth + 4;
  localparam int unsigned MomWidth  = DataWidth + 3;
  // speed times momentum, and after the fraction shift
  localparam int unsigned MprWidth  = MomWidth + SpeedWidth + 1;
  localparam int unsigned MWidth    = MprWidth - FracBits;
  // long division of |m| * 2^F by density
  localparam int unsigned RemWidth  = MWidth + FracBits;
  localparam int unsigned QuotBits  = DataWidth + 1;
  // equilibrium terms, e.u reaches twice the data range on diagonals
  localparam int unsigned EuWidth   = DataWidth + 2;
  localparam int unsigned SqWidth   = 2 * EuWidth - FracBits;
  localparam int unsigned WgtWidth  = FracBits + 2;
  localparam int unsigned PolyWidth = DataWidth + 10;
  localparam int unsigned FeqWidth  = DataWidth + 3;

  localparam int unsigned NumQueue  = 2;

  typedef logic signed [DataWidth-1:0] data_t;

  localparam data_t DataMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam data_t DataMin = {1'b1, {(DataWidth-1){1'b0}}};

  localparam logic signed [WgtWidth-1:0] WgtRest =
    WgtWidth'(((longint'(4) << FracBits) + 4) / 9);
  localparam logic signed [WgtWidth-1:0] WgtAxis =
    WgtWidth'(((longint'(1) << FracBits) + 4) / 9);
  localparam logic signed [WgtWidth-1:0] WgtDiag =
    WgtWidth'(((longint'(1) << FracBits) + 18) / 36);

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_RELAX_RATE    = 1'b0,
    CFG_LATTICE_SPEED = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    data_t dist_rest;
    data_t dist_east;
    data_t dist_north;
    data_t dist_west;
    data_t dist_south;
    data_t dist_northeast;
    data_t dist_northwest;
    data_t dist_southwest;
    data_t dist_southeast;
  } in_item_t;

  typedef struct packed {
    data_t new_rest;
    data_t new_east;
    data_t new_north;
    data_t new_west;
    data_t new_south;
    data_t new_northeast;
    data_t new_northwest;
    data_t new_southwest;
    data_t new_southeast;
    data_t cell_density;
    data_t vel_x;
    data_t vel_y;
  } out_item_t;

  // classified cell: distributions by direction index, rest first
  typedef struct packed {
    data_t [NumDir-1:0]          dist_v;
    data_t                       rho;
    logic signed [MomWidth-1:0]  mom_x;
    logic signed [MomWidth-1:0]  mom_y;
  } front_item_t;

  typedef struct packed {
    data_t [NumDir-1:0] dist_v;
    data_t              rho;
  } side_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ rtl/d2q9_front.sv @@
module d2q9_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  d2q9_pkg::in_item_t     in_item_i,
  input  d2q9_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output d2q9_pkg::front_item_t  push_item_o
);

  logic                  valid_q;
  d2q9_pkg::in_item_t    item_q;
  d2q9_pkg::data_t [d2q9_pkg::NumDir-1:0] dist_v;
  logic signed [d2q9_pkg::SumWidth-1:0] rho_sum;
  logic                  accept;

  assign in_stall_o = valid_q & q_status_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = valid_q & ~q_status_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  always_comb begin
    dist_v[0] = item_q.dist_rest;
    dist_v[1] = item_q.dist_east;
    dist_v[2] = item_q.dist_north;
    dist_v[3] = item_q.dist_west;
    dist_v[4] = item_q.dist_south;
    dist_v[5] = item_q.dist_northeast;
    dist_v[6] = item_q.dist_northwest;
    dist_v[7] = item_q.dist_southwest;
    dist_v[8] = item_q.dist_southeast;
  end

  always_comb begin
    rho_sum = '0;
    for (int i = 0; i < d2q9_pkg::NumDir; i++) begin
      rho_sum = rho_sum + d2q9_pkg::SumWidth'(dist_v[i]);
    end
  end

  always_comb begin
    push_item_o.dist_v = dist_v;
    push_item_o.mom_x = d2q9_pkg::MomWidth'(dist_v[1]) - d2q9_pkg::MomWidth'(dist_v[3])
                      + d2q9_pkg::MomWidth'(dist_v[5]) - d2q9_pkg::MomWidth'(dist_v[6])
                      - d2q9_pkg::MomWidth'(dist_v[7]) + d2q9_pkg::MomWidth'(dist_v[8]);
    push_item_o.mom_y = d2q9_pkg::MomWidth'(dist_v[2]) - d2q9_pkg::MomWidth'(dist_v[4])
                      + d2q9_pkg::MomWidth'(dist_v[5]) + d2q9_pkg::MomWidth'(dist_v[6])
                      - d2q9_pkg::MomWidth'(dist_v[7]) - d2q9_pkg::MomWidth'(dist_v[8]);
    if (rho_sum > d2q9_pkg::SumWidth'(d2q9_pkg::DataMax)) begin
      push_item_o.rho = d2q9_pkg::DataMax;
    end else if (rho_sum < d2q9_pkg::SumWidth'(d2q9_pkg::DataMin)) begin
      push_item_o.rho = d2q9_pkg::DataMin;
    end else begin
      push_item_o.rho = rho_sum[d2q9_pkg::DataWidth-1:0];
    end
  end

endmodule

@@ rtl/d2q9_queue.sv @@
module d2q9_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  d2q9_pkg::front_item_t   push_item_i,
  input  logic                    pop_i,
  output d2q9_pkg::front_item_t   head_o,
  output d2q9_pkg::queue_status_t status_o
);

  localparam int unsigned PtrWidth = $clog2(d2q9_pkg::NumQueue);

  d2q9_pkg::front_item_t mem [d2q9_pkg::NumQueue];
  logic [PtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrWidth:0]     count_q;

  assign status_o.full  = (count_q == (PtrWidth+1)'(d2q9_pkg::NumQueue));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/d2q9_div.sv @@
module d2q9_div (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [d2q9_pkg::MWidth-1:0] num_i,
  input  d2q9_pkg::data_t                    den_i,
  output d2q9_pkg::data_t                    quot_o
);

  localparam int unsigned QB = d2q9_pkg::QuotBits;
  localparam int unsigned RW = d2q9_pkg::RemWidth;
  localparam int unsigned DW = d2q9_pkg::DataWidth;
  localparam logic [QB-1:0] NegLim = QB'(1) << (DW - 1);
  localparam logic [QB-1:0] PosLim = QB'(d2q9_pkg::DataMax);

  logic [RW-1:0] rem_q [QB+1];
  logic [DW-1:0] den_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic          neg_q [QB+1];
  logic          ovf_q [QB+1];
  logic          pos_q [QB+1];

  logic [d2q9_pkg::MWidth-1:0] mag;
  logic [RW-1:0]               rem0;
  logic [RW-1:0]               den_top;

  assign mag     = num_i[d2q9_pkg::MWidth-1] ? (~num_i + 1'b1) : num_i;
  assign rem0    = {mag, {d2q9_pkg::FracBits{1'b0}}};
  assign den_top = RW'(den_i[DW-1:0]) << QB;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= num_i[d2q9_pkg::MWidth-1];
      ovf_q[0] <= (rem0 >= den_top);
      pos_q[0] <= (den_i > 0);
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 1; j <= QB; j++) begin : g_stage
    localparam int unsigned Shift = QB - j;
    logic [RW-1:0] dsh;
    logic [RW:0]   trial;

    assign dsh   = RW'(den_q[j-1]) << Shift;
    assign trial = {1'b0, rem_q[j-1]} - {1'b0, dsh};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j] <= den_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
        pos_q[j] <= pos_q[j-1];
        if (!trial[RW]) begin
          rem_q[j] <= trial[RW-1:0];
          quo_q[j] <= quo_q[j-1] | (QB'(1) << Shift);
        end else begin
          rem_q[j] <= rem_q[j-1];
          quo_q[j] <= quo_q[j-1];
        end
      end
    end
  end

  always_comb begin
    if (!pos_q[QB]) begin
      quot_o = '0;
    end else if (neg_q[QB]) begin
      if (ovf_q[QB] || quo_q[QB] > NegLim) begin
        quot_o = d2q9_pkg::DataMin;
      end else begin
        quot_o = DW'(QB'(0) - quo_q[QB]);
      end
    end else if (ovf_q[QB] || quo_q[QB] > PosLim) begin
      quot_o = d2q9_pkg::DataMax;
    end else begin
      quot_o = quo_q[QB][DW-1:0];
    end
  end

endmodule

@@ rtl/d2q9_back.sv @@
module d2q9_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [d2q9_pkg::RateWidth-1:0]        rate_i,
  input  logic [d2q9_pkg::SpeedWidth-1:0]       speed_i,
  input  d2q9_pkg::front_item_t                 head_i,
  input  d2q9_pkg::queue_status_t               q_status_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output d2q9_pkg::out_item_t                   out_item_o
);

  localparam int unsigned QB         = d2q9_pkg::QuotBits;
  localparam int unsigned ND         = d2q9_pkg::NumDir;
  localparam int unsigned DW         = d2q9_pkg::DataWidth;
  localparam int unsigned FB         = d2q9_pkg::FracBits;
  localparam int unsigned VelStage   = QB + 2;
  localparam int unsigned SqStage    = QB + 3;
  localparam int unsigned PolyStage  = QB + 4;
  localparam int unsigned FeqStage   = QB + 5;
  localparam int unsigned ProdStage  = QB + 6;
  localparam int unsigned OutStage   = QB + 7;
  localparam int unsigned NumStages  = QB + 8;
  localparam int unsigned WrpWidth   = d2q9_pkg::WgtWidth + DW;
  localparam int unsigned FpWidth    = d2q9_pkg::PolyWidth + DW;
  localparam int unsigned DiffWidth  = d2q9_pkg::FeqWidth + 1;
  localparam int unsigned RpWidth    = d2q9_pkg::RateWidth + 1 + DiffWidth;
  localparam int unsigned NvWidth    = RpWidth - d2q9_pkg::RateFrac + 1;
  localparam longint FeqLim = longint'(1) << (DW + 1);
  localparam logic signed [d2q9_pkg::PolyWidth-1:0] OneQ =
    d2q9_pkg::PolyWidth'(longint'(1) << FB);

  logic                 adv;
  logic                 valid_q [NumStages];
  d2q9_pkg::side_t      side_q  [ProdStage+1];

  logic signed [d2q9_pkg::MprWidth-1:0] mpx, mpy;
  logic signed [d2q9_pkg::MWidth-1:0]   mx_q, my_q;
  d2q9_pkg::data_t                      qx, qy;
  d2q9_pkg::data_t                      velx_q [VelStage:ProdStage];
  d2q9_pkg::data_t                      vely_q [VelStage:ProdStage];

  logic signed [d2q9_pkg::EuWidth-1:0]  ux, uy, eup, eum;
  logic signed [d2q9_pkg::EuWidth-1:0]  eu_d  [ND];
  logic [d2q9_pkg::SqWidth-1:0]         sq_d  [ND];
  logic signed [d2q9_pkg::EuWidth-1:0]  eu_q  [ND];
  logic [d2q9_pkg::SqWidth-1:0]         sq_q  [ND];
  d2q9_pkg::data_t                      wr_d  [3];
  d2q9_pkg::data_t                      wr_s_q [3];
  d2q9_pkg::data_t                      wr_p_q [3];
  logic [d2q9_pkg::SqWidth:0]           uusq;
  logic signed [d2q9_pkg::PolyWidth-1:0] poly_d [ND];
  logic signed [d2q9_pkg::PolyWidth-1:0] poly_q [ND];
  logic signed [d2q9_pkg::FeqWidth-1:0]  feq_d  [ND];
  logic signed [d2q9_pkg::FeqWidth-1:0]  feq_q  [ND];
  logic signed [RpWidth-1:0]             prod_d [ND];
  logic signed [RpWidth-1:0]             prod_q [ND];
  d2q9_pkg::data_t                       nv     [ND];
  d2q9_pkg::out_item_t                   out_d, out_q;

  function automatic logic [d2q9_pkg::SqWidth-1:0] square_q(
    input logic signed [d2q9_pkg::EuWidth-1:0] v
  );
    logic signed [2*d2q9_pkg::EuWidth-1:0] p;
    p = v * v;
    return d2q9_pkg::SqWidth'(p >>> d2q9_pkg::FracBits);
  endfunction

  function automatic d2q9_pkg::data_t weight_rho(
    input logic signed [d2q9_pkg::WgtWidth-1:0] w,
    input d2q9_pkg::data_t                     rho
  );
    logic signed [WrpWidth-1:0] p;
    p = WrpWidth'(w) * WrpWidth'(rho);
    return d2q9_pkg::DataWidth'(p >>> d2q9_pkg::FracBits);
  endfunction

  // weight class: rest, axis, diagonal
  function automatic int unsigned wclass(input int unsigned i);
    return (i == 0) ? 0 : ((i < 5) ? 1 : 2);
  endfunction

  assign adv         = ~valid_q[OutStage] | ~out_stall_i;
  assign pop_o       = adv & ~q_status_i.empty;
  assign out_valid_o = valid_q[OutStage];
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumStages; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else if (adv) begin
      valid_q[0] <= ~q_status_i.empty;
      for (int k = 1; k < NumStages; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // momentum scaled by lattice speed
  assign mpx = d2q9_pkg::MprWidth'($signed({1'b0, speed_i}))
             * d2q9_pkg::MprWidth'(head_i.mom_x);
  assign mpy = d2q9_pkg::MprWidth'($signed({1'b0, speed_i}))
             * d2q9_pkg::MprWidth'(head_i.mom_y);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx_q        <= d2q9_pkg::MWidth'(mpx >>> FB);
      my_q        <= d2q9_pkg::MWidth'(mpy >>> FB);
      side_q[0]   <= {head_i.dist_v, head_i.rho};
      for (int k = 1; k <= ProdStage; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  d2q9_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (mx_q),
    .den_i  (side_q[0].rho),
    .quot_o (qx)
  );

  d2q9_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (my_q),
    .den_i  (side_q[0].rho),
    .quot_o (qy)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      velx_q[VelStage] <= qx;
      vely_q[VelStage] <= qy;
      for (int k = VelStage + 1; k <= ProdStage; k++) begin
        velx_q[k] <= velx_q[k-1];
        vely_q[k] <= vely_q[k-1];
      end
    end
  end

  // e.u per direction and its square, and weight times density per class
  always_comb begin
    ux  = d2q9_pkg::EuWidth'(velx_q[VelStage]);
    uy  = d2q9_pkg::EuWidth'(vely_q[VelStage]);
    eup = ux + uy;
    eum = ux - uy;
    eu_d[0] = '0;   eu_d[1] = ux;   eu_d[2] = uy;
    eu_d[3] = -ux;  eu_d[4] = -uy;  eu_d[5] = eup;
    eu_d[6] = -eum; eu_d[7] = -eup; eu_d[8] = eum;
    sq_d[0] = '0;
    sq_d[1] = square_q(ux);
    sq_d[2] = square_q(uy);
    sq_d[3] = sq_d[1];
    sq_d[4] = sq_d[2];
    sq_d[5] = square_q(eup);
    sq_d[6] = square_q(eum);
    sq_d[7] = sq_d[5];
    sq_d[8] = sq_d[6];
    wr_d[0] = weight_rho(d2q9_pkg::WgtRest, side_q[VelStage].rho);
    wr_d[1] = weight_rho(d2q9_pkg::WgtAxis, side_q[VelStage].rho);
    wr_d[2] = weight_rho(d2q9_pkg::WgtDiag, side_q[VelStage].rho);
  end

  always_comb begin
    uusq = (d2q9_pkg::SqWidth+1)'(sq_q[1]) + (d2q9_pkg::SqWidth+1)'(sq_q[2]);
    for (int i = 0; i < ND; i++) begin
      poly_d[i] = OneQ
                + d2q9_pkg::PolyWidth'(eu_q[i]) * d2q9_pkg::PolyWidth'(3)
                + d2q9_pkg::PolyWidth'((d2q9_pkg::PolyWidth'(sq_q[i]) * 9) >> 1)
                - d2q9_pkg::PolyWidth'((d2q9_pkg::PolyWidth'(uusq) * 3) >> 1);
    end
  end

  always_comb begin
    logic signed [FpWidth-1:0] p;
    logic signed [FpWidth-1:0] sh;
    for (int i = 0; i < ND; i++) begin
      p  = FpWidth'(wr_p_q[wclass(i)]) * FpWidth'(poly_q[i]);
      sh = p >>> FB;
      if (sh > FpWidth'(FeqLim)) begin
        feq_d[i] = d2q9_pkg::FeqWidth'(FeqLim);
      end else if (sh < -FpWidth'(FeqLim)) begin
        feq_d[i] = -d2q9_pkg::FeqWidth'(FeqLim);
      end else begin
        feq_d[i] = sh[d2q9_pkg::FeqWidth-1:0];
      end
    end
  end

  always_comb begin
    logic signed [DiffWidth-1:0] diff;
    for (int i = 0; i < ND; i++) begin
      diff      = DiffWidth'(side_q[FeqStage].dist_v[i]) - DiffWidth'(feq_q[i]);
      prod_d[i] = RpWidth'($signed({1'b0, rate_i})) * RpWidth'(diff);
    end
  end

  always_comb begin
    logic signed [NvWidth-1:0] v;
    for (int i = 0; i < ND; i++) begin
      v = NvWidth'(side_q[ProdStage].dist_v[i])
        - NvWidth'(prod_q[i] >>> d2q9_pkg::RateFrac);
      if (v > NvWidth'(d2q9_pkg::DataMax)) begin
        nv[i] = d2q9_pkg::DataMax;
      end else if (v < NvWidth'(d2q9_pkg::DataMin)) begin
        nv[i] = d2q9_pkg::DataMin;
      end else begin
        nv[i] = v[DW-1:0];
      end
    end
    out_d.new_rest      = nv[0];
    out_d.new_east      = nv[1];
    out_d.new_north     = nv[2];
    out_d.new_west      = nv[3];
    out_d.new_south     = nv[4];
    out_d.new_northeast = nv[5];
    out_d.new_northwest = nv[6];
    out_d.new_southwest = nv[7];
    out_d.new_southeast = nv[8];
    out_d.cell_density  = side_q[ProdStage].rho;
    out_d.vel_x         = velx_q[ProdStage];
    out_d.vel_y         = vely_q[ProdStage];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < ND; i++) begin
        eu_q[i]   <= eu_d[i];
        sq_q[i]   <= sq_d[i];
        poly_q[i] <= poly_d[i];
        feq_q[i]  <= feq_d[i];
        prod_q[i] <= prod_d[i];
      end
      for (int c = 0; c < 3; c++) begin
        wr_s_q[c] <= wr_d[c];
        wr_p_q[c] <= wr_s_q[c];
      end
      out_q <= out_d;
    end
  end

endmodule

@@ rtl/d2q9_lattice_bgk_cell_update.sv @@
// channel | valid      | stall      | payload
// in      | in_valid_i | in_stall_o | in_item_i  (d2q9_pkg::in_item_t)
// out     | out_valid_o| out_stall_i| out_item_o (d2q9_pkg::out_item_t)
// cfg     | cfg_we_i   | -          | cfg_idx_i, cfg_data_i
//
// one cell per cycle sustained while the output is not stalled; with an
// empty queue a cell passes from the input register to a queue slot,
// then to a 33-stage back pipeline set mostly by the two 26-stage long
// dividers (an entry stage, then one quotient bit per stage) for velocity.
// reset clears valid state only; relax_rate and lattice_speed reset to 1.0.
// an output stall freezes the whole back pipeline; the two-entry queue
// lets the input register keep taking items until it fills.
module d2q9_lattice_bgk_cell_update (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  d2q9_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output d2q9_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_we_i,
  input  logic [d2q9_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [d2q9_pkg::CfgWidth-1:0]        cfg_data_i
);

  logic [d2q9_pkg::RateWidth-1:0]  rate_q;
  logic [d2q9_pkg::SpeedWidth-1:0] speed_q;

  logic                    fq_push, fq_pop;
  d2q9_pkg::front_item_t   fq_in, fq_head;
  d2q9_pkg::queue_status_t fq_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= d2q9_pkg::RateWidth'(1) << d2q9_pkg::RateFrac;
      speed_q <= d2q9_pkg::SpeedWidth'(1) << d2q9_pkg::FracBits;
    end else if (cfg_we_i) begin
      unique case (d2q9_pkg::cfg_idx_e'(cfg_idx_i))
        d2q9_pkg::CFG_RELAX_RATE: begin
          rate_q <= cfg_data_i[d2q9_pkg::RateWidth-1:0];
        end
        d2q9_pkg::CFG_LATTICE_SPEED: begin
          speed_q <= cfg_data_i[d2q9_pkg::SpeedWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  d2q9_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_status_i  (fq_st),
    .push_o      (fq_push),
    .push_item_o (fq_in)
  );

  d2q9_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fq_push),
    .push_item_i (fq_in),
    .pop_i       (fq_pop),
    .head_o      (fq_head),
    .status_o    (fq_st)
  );

  d2q9_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rate_i      (rate_q),
    .speed_i     (speed_q),
    .head_i      (fq_head),
    .q_status_i  (fq_st),
    .pop_o       (fq_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_st.full |-> !fq_push)
    else $error("push into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_st.empty |-> !fq_pop)
    else $error("pop from empty queue");

  a_stall_needs_full_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> fq_st.full)
    else $error("input stalled with room in queue");

  a_zero_vel_nonpos_density: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ($signed(out_item_o.cell_density) <= 0))
      |-> (out_item_o.vel_x == '0 && out_item_o.vel_y == '0))
    else $error("nonzero velocity with nonpositive density");

endmodule

@@ test/d2q9_cell_checker.sv @@
module d2q9_cell_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  d2q9_pkg::in_item_t               in_item_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  d2q9_pkg::out_item_t              out_item_i,
  input  logic                             cfg_we_i,
  input  logic [d2q9_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [d2q9_pkg::CfgWidth-1:0]    cfg_data_i,
  output int                               mismatch_count_o,
  output int                               pending_cells_o
);

  localparam int unsigned Dw  = d2q9_pkg::DataWidth;
  localparam int unsigned Fb  = d2q9_pkg::FracBits;
  localparam int unsigned Rf  = d2q9_pkg::RateFrac;
  localparam int unsigned Nd  = d2q9_pkg::NumDir;

  localparam longint OneQ    = longint'(1) << Fb;
  localparam longint DMax    = (longint'(1) << (Dw - 1)) - 1;
  localparam longint DMin    = -DMax - 1;
  localparam longint PolyLim = (longint'(1) << (63 - Dw)) - 1;
  localparam longint FeqLim  = longint'(1) << (Dw + 1);

  localparam int DirX [Nd] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DirY [Nd] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

  localparam string FieldName [12] = '{"new_rest", "new_east", "new_north", "new_west",
    "new_south", "new_northeast", "new_northwest", "new_southwest", "new_southeast",
    "cell_density", "vel_x", "vel_y"};

  longint unsigned     omega_q;
  longint unsigned     speed_q;
  d2q9_pkg::out_item_t expected_cells [$];
  int                  mismatches;

  assign mismatch_count_o = mismatches;
  assign pending_cells_o  = expected_cells.size();

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sq_frac(longint v);
    longint a;
    a = v < 0 ? -v : v;
    return (a * a) >>> Fb;
  endfunction

  function automatic longint flow_speed(longint msum, longint rho);
    longint ch, cl, m, q, r, qlim;
    ch = longint'(speed_q >> Fb);
    cl = longint'(speed_q & ((64'd1 << Fb) - 1));
    m  = ch * msum + ((cl * msum) >>> Fb);
    if (rho <= 0) return 0;
    q = m / rho;
    r = m % rho;
    qlim = DMax >>> Fb;
    if (q > qlim + 1) return DMax;
    if (q < -(qlim + 2)) return DMin;
    return sat(q * OneQ + (r * OneQ) / rho, DMin, DMax);
  endfunction

  function automatic d2q9_pkg::out_item_t collide_cell(d2q9_pkg::in_item_t cin);
    logic [Nd*Dw-1:0] flat;
    longint f [Nd];
    longint w [Nd];
    longint rho, mx, my, ux, uy, uusq, eu, poly, wr, feq, nv;
    d2q9_pkg::data_t res [12];
    d2q9_pkg::out_item_t o;
    flat = cin;
    rho = 0; mx = 0; my = 0;
    for (int i = 0; i < Nd; i++) begin
      f[i] = longint'(d2q9_pkg::data_t'(flat[(Nd-1-i)*Dw +: Dw]));
      w[i] = i == 0 ? longint'(d2q9_pkg::WgtRest)
           : (i < 5 ? longint'(d2q9_pkg::WgtAxis) : longint'(d2q9_pkg::WgtDiag));
      rho += f[i];
      mx += DirX[i] * f[i];
      my += DirY[i] * f[i];
    end
    rho = sat(rho, DMin, DMax);
    ux = flow_speed(mx, rho);
    uy = flow_speed(my, rho);
    uusq = sq_frac(ux) + sq_frac(uy);
    for (int i = 0; i < Nd; i++) begin
      eu = DirX[i] * ux + DirY[i] * uy;
      poly = OneQ + 3 * eu + ((9 * sq_frac(eu)) >>> 1) - ((3 * uusq) >>> 1);
      poly = sat(poly, -PolyLim, PolyLim);
      wr = (w[i] * rho) >>> Fb;
      feq = sat((wr * poly) >>> Fb, -FeqLim, FeqLim);
      nv = f[i] - ((longint'(omega_q) * (f[i] - feq)) >>> Rf);
      res[i] = d2q9_pkg::data_t'(sat(nv, DMin, DMax));
    end
    res[9]  = d2q9_pkg::data_t'(rho);
    res[10] = d2q9_pkg::data_t'(ux);
    res[11] = d2q9_pkg::data_t'(uy);
    o = {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8],
         res[9], res[10], res[11]};
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [12*Dw-1:0] got, want;
    if (!rst_ni) begin
      omega_q <= 64'd1 << Rf;
      speed_q <= 64'd1 << Fb;
      expected_cells.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        if (d2q9_pkg::cfg_idx_e'(cfg_idx_i) == d2q9_pkg::CFG_RELAX_RATE)
          omega_q <= cfg_data_i & ((64'd1 << d2q9_pkg::RateWidth) - 1);
        else if (d2q9_pkg::cfg_idx_e'(cfg_idx_i) == d2q9_pkg::CFG_LATTICE_SPEED)
          speed_q <= cfg_data_i & ((64'd1 << d2q9_pkg::SpeedWidth) - 1);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_cells.size() == 0) begin
          $error("unexpected result item %h", out_item_i);
          mismatches++;
        end else begin
          got = out_item_i;
          want = expected_cells.pop_front();
          for (int k = 0; k < 12; k++)
            if (got[(11-k)*Dw +: Dw] !== want[(11-k)*Dw +: Dw]) begin
              $error("%s: expected %0d, got %0d", FieldName[k],
                     d2q9_pkg::data_t'(want[(11-k)*Dw +: Dw]),
                     d2q9_pkg::data_t'(got[(11-k)*Dw +: Dw]));
              mismatches++;
            end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_cells.push_back(collide_cell(in_item_i));
    end
  end
endmodule

@@ test/tb_d2q9_lattice_bgk_cell_update.sv @@
module tb_d2q9_lattice_bgk_cell_update;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles  = 40;
  localparam int OneQ          = 1 << d2q9_pkg::FracBits;
  localparam int unsigned Nd   = d2q9_pkg::NumDir;
  localparam int unsigned Cw   = d2q9_pkg::CfgWidth;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid;
  logic                                 in_stall;
  d2q9_pkg::in_item_t                   in_item;
  logic                                 out_valid;
  logic                                 out_stall;
  d2q9_pkg::out_item_t                  out_item;
  logic                                 cfg_we;
  logic [d2q9_pkg::CfgIdxWidth-1:0]     cfg_idx;
  logic [Cw-1:0]                        cfg_data;
  int                                   mismatch_count;
  int                                   pending_cells;
  bit                                   quiet;
  int                                   idle_cycles;

  d2q9_lattice_bgk_cell_update uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  d2q9_cell_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_item_i       (out_item),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_cells_o  (pending_cells)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls in bursts, with calm stretches
  initial begin
    int burst;
    int calm;
    burst = 0;
    calm = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (calm > 0) calm--;
      else if ($urandom_range(0, 99) == 0) calm = $urandom_range(50, 150);
      if (quiet || calm > 0) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // sender gap before some cells unless quiet, then hold until accepted
  task automatic push_cell(d2q9_pkg::in_item_t cell_item);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= cell_item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cells != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(d2q9_pkg::cfg_idx_e idx, logic [Cw-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic d2q9_pkg::in_item_t uniform_cell(int spread);
    d2q9_pkg::data_t d [Nd];
    for (int i = 0; i < Nd; i++)
      d[i] = spread == 0 ? d2q9_pkg::data_t'($urandom())
                         : d2q9_pkg::data_t'($urandom_range(0, 2 * spread) - spread);
    return {d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7], d[8]};
  endfunction

  // near-equilibrium cell: weight times density plus a small flow disturbance
  function automatic d2q9_pkg::in_item_t fluid_cell();
    d2q9_pkg::data_t d [Nd];
    int rho;
    int noise;
    rho = $urandom_range(OneQ / 4, 3 * OneQ);
    noise = $urandom_range(1, OneQ / 8);
    for (int i = 0; i < Nd; i++)
      d[i] = d2q9_pkg::data_t'((i == 0 ? rho * 4 / 9 : (i < 5 ? rho / 9 : rho / 36))
                               + $urandom_range(0, 2 * noise) - noise);
    return {d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7], d[8]};
  endfunction

  task automatic random_cells(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) push_cell(fluid_cell());
      else if (pick < 9) push_cell(uniform_cell(0));
      else push_cell(uniform_cell(OneQ));
    end
  endtask

  initial begin
    d2q9_pkg::data_t hi_e;
    d2q9_pkg::data_t dmax;
    d2q9_pkg::data_t dmin;
    d2q9_pkg::data_t zero;
    rst_ni = 1'b0;
    quiet = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_idx = d2q9_pkg::CFG_RELAX_RATE;
    cfg_data = '0;
    dmax = d2q9_pkg::DataMax;
    dmin = d2q9_pkg::DataMin;
    zero = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero and negative density, saturating flow
    push_cell('0);
    push_cell({Nd{dmax}});
    push_cell({Nd{dmin}});
    push_cell({dmax, dmin, dmax, dmin, dmax, dmin, dmax, dmin, zero});
    push_cell({d2q9_pkg::data_t'(OneQ), d2q9_pkg::data_t'(-OneQ), {7{zero}}});
    push_cell({d2q9_pkg::data_t'(-OneQ), {8{d2q9_pkg::data_t'(OneQ / 16)}}});
    push_cell({d2q9_pkg::data_t'(1), dmax, {7{zero}}});
    push_cell({d2q9_pkg::data_t'(1), {4{zero}}, {3{zero}}, dmin});
    push_cell({d2q9_pkg::data_t'(2), {2{zero}}, dmax, dmax, {4{zero}}});
    hi_e = d2q9_pkg::data_t'(OneQ / 9);
    push_cell({d2q9_pkg::data_t'(4 * OneQ / 9), {4{hi_e}},
               {4{d2q9_pkg::data_t'(OneQ / 36)}}});
    push_cell({{8{zero}}, d2q9_pkg::data_t'(3)});
    for (int i = 0; i < 8; i++) push_cell(fluid_cell());
    random_cells(150);
    drain_pipe();

    write_reg(d2q9_pkg::CFG_RELAX_RATE, '0);
    write_reg(d2q9_pkg::CFG_LATTICE_SPEED, '0);
    random_cells(150);
    drain_pipe();

    write_reg(d2q9_pkg::CFG_RELAX_RATE, {Cw{1'b1}});
    write_reg(d2q9_pkg::CFG_LATTICE_SPEED, {Cw{1'b1}});
    push_cell({d2q9_pkg::data_t'(1), dmax, {7{zero}}});
    push_cell({Nd{dmax}});
    random_cells(200);
    drain_pipe();

    write_reg(d2q9_pkg::CFG_RELAX_RATE,
              Cw'($urandom_range(1, (1 << d2q9_pkg::RateWidth) - 1)));
    write_reg(d2q9_pkg::CFG_LATTICE_SPEED, Cw'($urandom_range(OneQ / 4, 2 * OneQ)));
    random_cells(250);
    drain_pipe();

    write_reg(d2q9_pkg::CFG_RELAX_RATE, Cw'(OneQ * 3 / 2) | 24'hE00000);
    write_reg(d2q9_pkg::CFG_LATTICE_SPEED, Cw'(OneQ));
    quiet = 1'b1;
    random_cells(250);
    drain_pipe();

    if (mismatch_count == 0 && pending_cells == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/d2q9_pkg.sv
rtl/d2q9_front.sv
rtl/d2q9_queue.sv
rtl/d2q9_div.sv
rtl/d2q9_back.sv
rtl/d2q9_lattice_bgk_cell_update.sv
test/d2q9_cell_checker.sv
test/tb_d2q9_lattice_bgk_cell_update.sv
